/* rtl/hfc_pkg.sv */
// Package for the heat flow unit: field widths, register indexes and sequencer states.
// Used by hfc_div and heat_flow_between_cells_unit; depends on nothing else.

package hfc_pkg;

  localparam int MATERIAL_COUNT_DEF = 4;
  localparam int TEMP_WIDTH_DEF     = 24;

  localparam int MAT_SLOTS  = 4;
  localparam int MAT_W      = 2;
  localparam int MASK_W     = 4;
  localparam int COND_W     = 24;
  localparam int KPOS_W     = 23;
  localparam int KSUM_W     = 24;
  localparam int KPROD_W    = 46;
  localparam int FM_W       = 16;
  localparam int CF_W       = 16;
  localparam int FRAC_W     = 8;
  localparam int FLOW_W     = 48;
  localparam int MUL_BW     = 31;
  localparam int SPLIT_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [FM_W-1:0] FM_RESET = 16'd256;
  localparam logic [CF_W-1:0] CF_RESET = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COND_0,
    REG_COND_1,
    REG_COND_2,
    REG_COND_3,
    REG_FLUID_MASK,
    REG_MIX_ENABLE,
    REG_FLUID_MULT,
    REG_CELL_FACTOR
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_MUL_K,
    ST_DIV_GO,
    ST_DIV,
    ST_MUL_CF,
    ST_MUL_T,
    ST_MAG,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ADD,
    ST_OUT
  } hfc_state_e;

endpackage

/* rtl/hfc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, for k1*k2 / (k1+k2).
// Depends on hfc_pkg for the operand widths.

module hfc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hfc_pkg::KPROD_W-1:0] num_i,
  input  logic [hfc_pkg::KSUM_W-1:0]  den_i,
  output logic                        done_o,
  output logic [hfc_pkg::KPOS_W-1:0]  quot_o
);
  import hfc_pkg::*;

  localparam int CNT_W = $clog2(KPOS_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [KSUM_W-1:0] rem_q;
  logic [KSUM_W-1:0] den_q;
  logic [KPOS_W-1:0] quo_q;
  logic [KSUM_W:0]   trial;
  logic [KSUM_W:0]   trial_sub;
  logic              ge;

  assign trial     = {rem_q, quo_q[KPOS_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(KPOS_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= KSUM_W'(num_i[KPROD_W-1:KPOS_W]);
      quo_q <= num_i[KPOS_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[KSUM_W-1:0] : trial[KSUM_W-1:0];
      quo_q <= {quo_q[KPOS_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/heat_flow_between_cells_unit.sv */
// Heat flow between neighboring cells of a strip, one shared multiplier and a serial divider.
// A cell with a previous cell gives its flow after the k1*k2 product, 23 divider steps and the
// scaling multiplies (plus fluid multiply if it applies; K1 goes straight to output when a
// conductivity is not positive). The unit takes the next cell in the cycle after the result
// reaches the output register. A strip start cell is absorbed while idle. Reset clears the
// sequencer, previous cell and registers to defaults (fluid multiplier 1.0, cell factor 2.0).

module heat_flow_between_cells_unit #(
  parameter int MaterialCount = hfc_pkg::MATERIAL_COUNT_DEF,
  parameter int TempWidth     = hfc_pkg::TEMP_WIDTH_DEF
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  s_axis_tvalid,
  output logic                                                  s_axis_tready,
  // temperature, material
  input  logic [((TempWidth + hfc_pkg::MAT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // strip_start
  input  logic                                                  s_axis_tuser,
  output logic                                                  m_axis_tvalid,
  input  logic                                                  m_axis_tready,
  // flow
  output logic [hfc_pkg::FLOW_W-1:0]                            m_axis_tdata,
  // saturated
  output logic                                                  m_axis_tuser,
  input  logic                                                  cfg_we_i,
  input  logic [hfc_pkg::CFG_IDX_W-1:0]                         cfg_idx_i,
  input  logic [hfc_pkg::CFG_DATA_W-1:0]                        cfg_data_i
);
  import hfc_pkg::*;

  localparam int MUL_AW = (TempWidth > SPLIT_W) ? TempWidth : SPLIT_W;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int MAG_W  = (TempWidth + MUL_BW > FLOW_W + 1) ? TempWidth + MUL_BW : FLOW_W + 1;
  localparam int COND_HI = KPOS_W + CF_W - 1;
  localparam int MIX_SH  = SPLIT_W - FRAC_W;

  localparam logic [MAG_W-1:0] NEG_LIM = {{(MAG_W - FLOW_W){1'b0}}, 1'b1, {(FLOW_W - 1){1'b0}}};
  localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);
  localparam logic [FLOW_W-1:0] FLOW_MAX = {1'b0, {(FLOW_W - 1){1'b1}}};
  localparam logic [FLOW_W-1:0] FLOW_MIN = {1'b1, {(FLOW_W - 1){1'b0}}};

  hfc_state_e state_q, state_d;

  logic [COND_W-1:0] cond_q [MAT_SLOTS];
  logic [MASK_W-1:0] mask_q;
  logic              mix_q;
  logic [FM_W-1:0]   fm_q;
  logic [CF_W-1:0]   cf_q;

  logic signed [TempWidth-1:0] prev_t_q;
  logic [MAT_W-1:0]            prev_m_q;
  logic                        have_prev_q;

  logic [MAT_W-1:0]     opm_q;
  logic [KPOS_W-1:0]    k1_q, k2_q;
  logic                 neg_q;
  logic [TempWidth-1:0] dmag_q;
  logic                 fluid_q;
  logic [KSUM_W-1:0]    ksum_q;
  logic [PROD_W-1:0]    prod_q, acc_q;
  logic [MAG_W-1:0]     mag_q;

  logic                 m_valid_q;
  logic [FLOW_W-1:0]    m_flow_q;
  logic                 m_sat_q;

  logic signed [TempWidth-1:0] in_temp;
  logic [MAT_W-1:0]            in_mat;
  logic                        in_start;
  logic                        in_fire;
  logic                        need_result;
  logic signed [TempWidth:0]   diff;
  logic                        prev_fluid, cur_fluid;

  logic [MAT_W-1:0]  rd_addr;
  logic [COND_W-1:0] k_rd;
  logic [KPOS_W-1:0] k_pos;
  logic              k_zero;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  logic              div_start, div_done;
  logic [KPOS_W-1:0] div_quot;

  logic              sat;
  logic [MAG_W-1:0]  mag_c;
  logic [MAG_W-1:0]  mag_neg;
  logic [FLOW_W-1:0] flow;
  logic              out_load;

  assign in_temp     = s_axis_tdata[TempWidth-1:0];
  assign in_mat      = s_axis_tdata[TempWidth+MAT_W-1:TempWidth];
  assign in_start    = s_axis_tuser;
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign need_result = !in_start && have_prev_q;
  assign diff        = {prev_t_q[TempWidth-1], prev_t_q} - {in_temp[TempWidth-1], in_temp};

  assign prev_fluid = ({1'b0, prev_m_q} < 3'(MaterialCount)) && mask_q[prev_m_q];
  assign cur_fluid  = ({1'b0, in_mat} < 3'(MaterialCount)) && mask_q[in_mat];

  // Single read port on the conductivity registers: the new cell's material while idle,
  // the previous cell's material in the K1 state that follows.
  assign rd_addr = (state_q == ST_IDLE) ? in_mat : opm_q;
  assign k_rd    = cond_q[rd_addr];
  assign k_pos   = ({1'b0, rd_addr} < 3'(MaterialCount) && !k_rd[COND_W-1]) ?
                   k_rd[KPOS_W-1:0] : '0;
  assign k_zero  = (k_pos == '0) || (k2_q == '0);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_SLOTS; i++) begin
        cond_q[i] <= '0;
      end
      mask_q <= '0;
      mix_q  <= 1'b0;
      fm_q   <= FM_RESET;
      cf_q   <= CF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COND_0, REG_COND_1, REG_COND_2, REG_COND_3: begin
          cond_q[cfg_idx_i[MAT_W-1:0]] <= cfg_data_i[COND_W-1:0];
        end
        REG_FLUID_MASK:  mask_q <= cfg_data_i[MASK_W-1:0];
        REG_MIX_ENABLE:  mix_q  <= cfg_data_i[0];
        REG_FLUID_MULT:  fm_q   <= cfg_data_i[FM_W-1:0];
        REG_CELL_FACTOR: cf_q   <= cfg_data_i[CF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      prev_t_q    <= '0;
      prev_m_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        have_prev_q <= 1'b1;
        prev_t_q    <= in_temp;
        prev_m_q    <= in_mat;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire && need_result) state_d = ST_K1;
      ST_K1:     state_d = k_zero ? ST_OUT : ST_MUL_K;
      ST_MUL_K:  state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_MUL_CF;
      ST_MUL_CF: state_d = ST_MUL_T;
      ST_MUL_T:  state_d = ST_MAG;
      ST_MAG:    state_d = fluid_q ? ST_MUL_HI : ST_OUT;
      ST_MUL_HI: state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_ADD;
      ST_ADD:    state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      ST_MUL_K: begin
        mul_a = MUL_AW'(k1_q);
        mul_b = MUL_BW'(k2_q);
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_MUL_CF: begin
        mul_a = MUL_AW'(div_quot);
        mul_b = MUL_BW'(cf_q);
      end
      ST_MUL_T: begin
        mul_a = MUL_AW'(dmag_q);
        mul_b = prod_q[COND_HI:FRAC_W];
      end
      ST_MUL_HI: begin
        mul_a = MUL_AW'(mag_q[TempWidth+KPOS_W-1:SPLIT_W]);
        mul_b = MUL_BW'(fm_q);
      end
      ST_MUL_LO: begin
        mul_a = MUL_AW'(mag_q[SPLIT_W-1:0]);
        mul_b = MUL_BW'(fm_q);
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  hfc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q[KPROD_W-1:0]),
    .den_i   (ksum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire && need_result) begin
          opm_q   <= prev_m_q;
          k2_q    <= k_pos;
          neg_q   <= diff[TempWidth];
          dmag_q  <= diff[TempWidth] ? TempWidth'(-diff) : diff[TempWidth-1:0];
          fluid_q <= mix_q && prev_fluid && cur_fluid;
        end
      end
      ST_K1: begin
        k1_q <= k_pos;
        if (k_zero) begin
          mag_q <= '0;
        end
      end
      ST_MUL_K: begin
        prod_q <= mul_p;
        ksum_q <= KSUM_W'(k1_q) + KSUM_W'(k2_q);
      end
      ST_MUL_CF, ST_MUL_T, ST_MUL_HI: prod_q <= mul_p;
      ST_MAG: mag_q <= MAG_W'(prod_q[TempWidth+MUL_BW-1:FRAC_W]);
      ST_MUL_LO: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_ADD: mag_q <= (MAG_W'(acc_q) << MIX_SH) + MAG_W'(prod_q >> FRAC_W);
      default: ;
    endcase
  end

  assign sat     = neg_q ? (mag_q > NEG_LIM) : (mag_q > POS_LIM);
  assign mag_c   = sat ? (neg_q ? NEG_LIM : POS_LIM) : mag_q;
  assign mag_neg = MAG_W'(0) - mag_c;
  assign flow    = neg_q ? mag_neg[FLOW_W-1:0] : mag_c[FLOW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_flow_q <= flow;
      m_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_flow_q;
  assign m_axis_tuser  = m_sat_q;

`ifndef NO_ASSERTIONS
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_OUT))
    else $error("Result appeared without passing the output state.");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("Divider finished outside the divide state.");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_sat_q) |-> (m_flow_q == FLOW_MAX || m_flow_q == FLOW_MIN))
    else $error("Saturated flow is not at a range limit.");

  a_pair_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !s_axis_tuser && have_prev_q) |=> (state_q == ST_K1))
    else $error("A cell with a previous cell did not start a computation.");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for heat_flow_between_cells_unit: directed table, then random strips.
// Expected flows: a predictor here, or the table for known rows; needs hfc_pkg and the DUT.

module tb;
  import hfc_pkg::*;

  localparam int TDATA_W          = ((TEMP_WIDTH_DEF + MAT_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES    = 40;
  localparam int CONFIGS_PER_MODE = 3;
  localparam int CELLS_PER_CONFIG = 50;

  typedef enum logic {
    ROW_CELL,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    cfg_reg_e                     idx;
    logic [CFG_DATA_W-1:0]        val;
    logic [TEMP_WIDTH_DEF-1:0]    temp;
    logic [MAT_W-1:0]             mat;
    logic                         start;
    logic                         known;
    logic [FLOW_W-1:0]            flow;
    logic                         sat;
  } stim_row_t;

  typedef struct packed {
    logic [FLOW_W-1:0] flow;
    logic              sat;
  } flow_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [FLOW_W-1:0]     m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predictor copy of the registers and of the previous cell.
  logic signed [COND_W-1:0]         conductivity [MAT_SLOTS];
  logic [MASK_W-1:0]                fluid_mask  = '0;
  logic                             mix_on      = 1'b0;
  logic [FM_W-1:0]                  fluid_gain  = FM_RESET;
  logic [CF_W-1:0]                  cell_scale  = CF_RESET;
  logic signed [TEMP_WIDTH_DEF-1:0] last_temp   = '0;
  logic [MAT_W-1:0]                 last_material = '0;
  logic                             have_last   = 1'b0;

  flow_result_t pending_flows [$];
  flow_result_t oldest;
  int           error_count       = 0;
  int           sender_idle_pct   = 28;
  int           receiver_idle_pct = 70;

  stim_row_t directed_rows [31] = '{
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h000064, 2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h800000, 2'd1, 1'b0, 1'b1, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h7FFFFF, 2'd3, 1'b0, 1'b1, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h000000, 2'd2, 1'b1, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_COND_0,      24'h7FFFFF, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_COND_1,      24'h7FFFFF, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_COND_2,      24'h800000, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_COND_3,      24'h000100, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_FLUID_MASK,  24'hFFFFFB, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_MIX_ENABLE,  24'h000001, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_FLUID_MULT,  24'h00FFFF, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_CELL_FACTOR, 24'h00FFFF, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h7FFFFF, 2'd0, 1'b1, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h800000, 2'd1, 1'b0, 1'b1,
      48'h7FFF_FFFF_FFFF, 1'b1},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h7FFFFF, 2'd0, 1'b0, 1'b1,
      48'h8000_0000_0000, 1'b1},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h000005, 2'd2, 1'b0, 1'b1, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'hFFFFFB, 2'd3, 1'b0, 1'b1, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h0003E8, 2'd3, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'hFFFC18, 2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h000000, 2'd1, 1'b1, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'hFFFFFF, 2'd1, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_MIX_ENABLE,  24'hFFFFFE, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_FLUID_MULT,  24'h000000, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_CELL_FACTOR, 24'h000000, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h7FFFFF, 2'd0, 1'b0, 1'b1, 48'h0, 1'b0},
    '{ROW_CFG,  REG_CELL_FACTOR, 24'hFFFFFF, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_FLUID_MASK,  24'h000000, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_MIX_ENABLE,  24'h000001, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h800000, 2'd1, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CFG,  REG_FLUID_MASK,  24'h00000F, 24'h0,      2'd0, 1'b0, 1'b0, 48'h0, 1'b0},
    '{ROW_CELL, REG_COND_0,      24'h0,      24'h7FFFFF, 2'd0, 1'b0, 1'b1, 48'h0, 1'b0}
  };

  heat_flow_between_cells_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    foreach (conductivity[i]) conductivity[i] = '0;
  end

  function automatic bit predict_flow(input logic signed [TEMP_WIDTH_DEF-1:0] temp,
                                      input logic [MAT_W-1:0] mat, input logic start,
                                      output flow_result_t res);
    longint unsigned k_prev, k_this, cnd, mag, hi, lo, hp;
    longint          diff;
    bit              neg;
    res = '0;
    if (start || !have_last) begin
      last_temp     = temp;
      last_material = mat;
      have_last     = 1'b1;
      return 1'b0;
    end
    k_prev = (conductivity[last_material] > 0) ? longint'(conductivity[last_material]) : 0;
    k_this = (conductivity[mat] > 0) ? longint'(conductivity[mat]) : 0;
    if (k_prev == 0 || k_this == 0) cnd = 0;
    else cnd = (((k_prev * k_this) / (k_prev + k_this)) * cell_scale) >> FRAC_W;
    diff = longint'(last_temp) - longint'(temp);
    neg  = diff < 0;
    mag  = neg ? -diff : diff;
    mag  = (mag * cnd) >> FRAC_W;
    if (mix_on && fluid_mask[last_material] && fluid_mask[mat]) begin
      hi = mag >> 16;
      lo = mag & 64'hFFFF;
      hp = hi * fluid_gain;
      if (hp >= (64'd1 << 40)) mag = 64'h8000_0000_0001;
      else mag = (hp << FRAC_W) + ((lo * fluid_gain) >> FRAC_W);
    end
    if (neg) begin
      if (mag > 64'h8000_0000_0000) begin
        mag     = 64'h8000_0000_0000;
        res.sat = 1'b1;
      end
      mag = -mag;
    end else if (mag > 64'h7FFF_FFFF_FFFF) begin
      mag     = 64'h7FFF_FFFF_FFFF;
      res.sat = 1'b1;
    end
    res.flow      = mag[FLOW_W-1:0];
    last_temp     = temp;
    last_material = mat;
    return 1'b1;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_COND_0, REG_COND_1, REG_COND_2, REG_COND_3: conductivity[idx[MAT_W-1:0]] = data;
      REG_FLUID_MASK:  fluid_mask = data[MASK_W-1:0];
      REG_MIX_ENABLE:  mix_on     = data[0];
      REG_FLUID_MULT:  fluid_gain = data[FM_W-1:0];
      REG_CELL_FACTOR: cell_scale = data[CF_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_cell(input logic [TEMP_WIDTH_DEF-1:0] temp, input logic [MAT_W-1:0] mat,
                           input logic start, input logic known, input flow_result_t typed);
    flow_result_t res;
    cfg_we_i <= 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({mat, temp});
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_flow(temp, mat, start, res)) pending_flows.push_back(known ? typed : res);
  endtask

  task automatic drain_flows();
    s_axis_tvalid <= 1'b0;
    while (pending_flows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_flows.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got flow %h saturated %b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        oldest = pending_flows.pop_front();
        if (m_axis_tdata !== oldest.flow) begin
          $display("%0t: flow mismatch, expected %h, got %h", $time, oldest.flow, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== oldest.sat) begin
          $display("%0t: saturated mismatch, expected %b, got %b",
                   $time, oldest.sat, m_axis_tuser);
          error_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    bit                        cells_since_drain;
    int                        pick;
    logic [CFG_DATA_W-1:0]     data;
    logic [TEMP_WIDTH_DEF-1:0] temp;
    cells_since_drain = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (cells_since_drain) begin
          drain_flows();
          cells_since_drain = 1'b0;
        end
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_cell(directed_rows[i].temp, directed_rows[i].mat, directed_rows[i].start,
                  directed_rows[i].known, {directed_rows[i].flow, directed_rows[i].sat});
        cells_since_drain = 1'b1;
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          sender_idle_pct   = 28;
          receiver_idle_pct = 70;
        end
        1: begin
          sender_idle_pct   = 70;
          receiver_idle_pct = 28;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < CONFIGS_PER_MODE; c++) begin
        drain_flows();
        for (int r = 0; r < 8; r++) begin
          pick = $urandom_range(0, 5);
          data = CFG_DATA_W'($urandom());
          case (cfg_reg_e'(r))
            REG_COND_0, REG_COND_1, REG_COND_2, REG_COND_3: begin
              case (pick)
                0: data = 24'h7FFFFF;
                1: data = 24'h800000;
                2: data = '0;
                3: data = CFG_DATA_W'($urandom_range(1, 4096));
                default: ;
              endcase
            end
            REG_FLUID_MULT, REG_CELL_FACTOR: begin
              case (pick)
                0: data[15:0] = 16'hFFFF;
                1: data[15:0] = 16'h0000;
                2: data[15:0] = 16'h0100;
                default: ;
              endcase
            end
            default: ;
          endcase
          write_reg(cfg_reg_e'(r), data);
        end
        for (int n = 0; n < CELLS_PER_CONFIG; n++) begin
          if (c == 0 && n == CELLS_PER_CONFIG / 2) drain_flows();
          case ($urandom_range(0, 5))
            0: temp = 24'h7FFFFF;
            1: temp = 24'h800000;
            2: temp = TEMP_WIDTH_DEF'(int'($urandom_range(0, 511)) - 256);
            default: temp = TEMP_WIDTH_DEF'($urandom());
          endcase
          send_cell(temp, MAT_W'($urandom_range(0, 3)), $urandom_range(0, 9) == 0, 1'b0, '0);
        end
      end
    end

    drain_flows();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hfc_pkg.sv
rtl/hfc_div.sv
rtl/heat_flow_between_cells_unit.sv
tb/sv/tb.sv
